[hdl/fdar_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, register codes, types and back-end states for the frame DC/RMS block.
package fdar_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VALID_DEF     = 4096;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int CHANNEL_COUNT_DEF = 2;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Field and accumulator widths
  localparam int N_W       = 13;
  localparam int POS_W     = 14;
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 36;
  localparam int OUT_W     = 20;
  localparam int DISC_W    = 10;
  localparam int SCALE_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Back-end arithmetic widths
  localparam int SQ_HALF_W  = SQ_W / 2;
  localparam int PROD_A_W   = N_W + SQ_W;
  localparam int PROD_B_W   = 2 * SUM_W;
  localparam int DIVISOR_W  = 2 * N_W;
  localparam int FRAC_W     = 16;
  localparam int DIVIDEND_W = PROD_A_W + FRAC_W;
  localparam int ROOT_W     = 32;
  localparam int X_W        = 2 * ROOT_W;
  localparam int MV_SHIFT   = 20;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Register reset values
  localparam logic [DISC_W-1:0]  DISCARD_RST = 10'd0;
  localparam logic [N_W-1:0]     VALID_RST   = 13'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd40010;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISCARD = 2'd0,
    CFG_VALID   = 2'd1,
    CFG_SCALE   = 2'd2
  } cfg_reg_t;

  // One completed frame handed from front to back
  typedef struct packed {
    logic             chan;
    logic [N_W-1:0]   n;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
  } job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } qstat_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_VAR,
    BK_DC_DIV,
    BK_RMS_DIV,
    BK_SQRT,
    BK_SCALE,
    BK_EMIT
  } bk_state_t;

endpackage

[hdl/frame_dc_and_ac_rms.sv]
`timescale 1ns / 1ps
// Top level: per-channel frame mean and AC RMS with DC removal.
//
// Samples enter on start/in_chan/in_sample and transfer at a clock edge where
// start is high and busy is low. Each channel keeps its own frame: leading
// samples are dropped, the rest are summed with their squares, and a full frame
// produces one result. Results appear for exactly one cycle with out_valid high;
// the receiver cannot stall, so the result must be taken in that cycle.
// The front end takes one sample per cycle while busy is low and hands a full
// frame to the queue in the cycle after its last sample transfers. Per frame,
// the back end pops it, forms products and variance, runs two divisions (65
// quotient bits each) on its shared divider, takes a square root two radicand
// bits at a time, scales the root and raises out_valid. Frames that come faster
// than the back end finishes them back up into the queue; busy rises when the
// queue is full, or one short of full while a sample is in the front stage.
// Configuration registers are written over cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high, and writes take effect at once, so they
// belong in gaps where no sample or frame is in flight. Synchronous reset clears
// per-channel frame state and the queue, and restores the register defaults.
module frame_dc_and_ac_rms #(
  parameter int MAX_VALID_SAMPLES = fdar_pkg::MAX_VALID_DEF,
  parameter int SAMPLE_BITS       = fdar_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNEL_COUNT     = fdar_pkg::CHANNEL_COUNT_DEF,
  parameter int QUEUE_DEPTH       = fdar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_chan,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdar_pkg::SCALE_W-1:0]   cfg_data,
  output logic                           out_valid,
  output logic                           out_chan,
  output logic [fdar_pkg::N_W-1:0]       out_sample_count,
  output logic [fdar_pkg::OUT_W-1:0]     out_dc_code_q8,
  output logic [fdar_pkg::OUT_W-1:0]     out_rms_code_q8,
  output logic [fdar_pkg::OUT_W-1:0]     out_rms_mv_q4
);

  localparam int DISC_W  = fdar_pkg::DISC_W;
  localparam int N_W     = fdar_pkg::N_W;

  logic [DISC_W-1:0]            discard_r;
  logic [N_W-1:0]               valid_r;
  logic [fdar_pkg::SCALE_W-1:0] scale_r;

  logic                         push;
  logic                         pop;
  fdar_pkg::job_t               push_job;
  fdar_pkg::job_t               head_job;
  fdar_pkg::qstat_t             qstat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_r <= fdar_pkg::DISCARD_RST;
      valid_r   <= fdar_pkg::VALID_RST;
      scale_r   <= fdar_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (fdar_pkg::cfg_reg_t'(cfg_index))
        fdar_pkg::CFG_DISCARD: discard_r <= cfg_data[DISC_W-1:0];
        fdar_pkg::CFG_VALID:   valid_r   <= cfg_data[N_W-1:0];
        fdar_pkg::CFG_SCALE:   scale_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fdar_front #(
    .MAX_VALID_SAMPLES (MAX_VALID_SAMPLES),
    .SAMPLE_BITS       (SAMPLE_BITS),
    .CHANNEL_COUNT     (CHANNEL_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_chan       (in_chan),
    .in_sample     (in_sample),
    .discard_count (discard_r),
    .valid_count   (valid_r),
    .qstat         (qstat),
    .busy          (busy),
    .push          (push),
    .job           (push_job)
  );

  fdar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .stat      (qstat)
  );

  fdar_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qstat            (qstat),
    .head             (head_job),
    .mv_scale         (scale_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_chan         (out_chan),
    .out_sample_count (out_sample_count),
    .out_dc_code_q8   (out_dc_code_q8),
    .out_rms_code_q8  (out_rms_code_q8),
    .out_rms_mv_q4    (out_rms_mv_q4)
  );

  // Each frame takes many back-end cycles, so results never come in adjacent cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held for two cycles");

endmodule

[hdl/fdar_front.sv]
`timescale 1ns / 1ps
// Front end: takes samples, keeps per-channel position and sums, hands off full frames.
module fdar_front #(
  parameter int MAX_VALID_SAMPLES = fdar_pkg::MAX_VALID_DEF,
  parameter int SAMPLE_BITS       = fdar_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNEL_COUNT     = fdar_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_chan,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [fdar_pkg::DISC_W-1:0] discard_count,
  input  logic [fdar_pkg::N_W-1:0]    valid_count,
  input  fdar_pkg::qstat_t            qstat,
  output logic                        busy,
  output logic                        push,
  output fdar_pkg::job_t              job
);

  localparam int N_W   = fdar_pkg::N_W;
  localparam int POS_W = fdar_pkg::POS_W;
  localparam int SUM_W = fdar_pkg::SUM_W;
  localparam int SQ_W  = fdar_pkg::SQ_W;
  localparam int SQR_W = 2 * SAMPLE_BITS;
  localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic                   accept;
  logic                   chan_ok;

  // stage 1: sample and its square
  logic                   s1_valid_r;
  logic [CH_W-1:0]        s1_chan_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [SQR_W-1:0]       s1_sq_r;

  // per-channel frame state
  logic [POS_W-1:0]       pos_r [CHANNEL_COUNT];
  logic [SUM_W-1:0]       sum_r [CHANNEL_COUNT];
  logic [SQ_W-1:0]        sq_r  [CHANNEL_COUNT];

  logic [N_W-1:0]         n_eff;
  logic [POS_W-1:0]       pos;
  logic                   take;
  logic [POS_W:0]         fill;
  logic                   complete;
  logic [SUM_W-1:0]       sum_acc;
  logic [SQ_W-1:0]        sq_acc;
  logic [POS_W-1:0]       pos_nxt;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SQ_W-1:0]        sq_nxt;

  // Hold off while the queue cannot take the item already in flight
  assign busy    = qstat.full | (qstat.almost_full & s1_valid_r);
  assign accept  = start & ~busy;
  assign chan_ok = (32'(in_chan) < CHANNEL_COUNT);

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept & chan_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chan_r   <= CH_W'(in_chan);
      s1_sample_r <= in_sample;
      s1_sq_r     <= in_sample * in_sample;
    end
  end

  // Effective frame length: zero counts as one, clamp at the maximum
  always_comb begin
    if (valid_count == '0) begin
      n_eff = N_W'(1);
    end else if (32'(valid_count) > MAX_VALID_SAMPLES) begin
      n_eff = N_W'(MAX_VALID_SAMPLES);
    end else begin
      n_eff = valid_count;
    end
  end

  // Stage 2: skip, accumulate or close the frame
  always_comb begin
    pos      = pos_r[s1_chan_r];
    take     = (pos >= POS_W'(discard_count));
    fill     = (POS_W+1)'(pos) - (POS_W+1)'(discard_count) + (POS_W+1)'(1);
    complete = take && (fill >= (POS_W+1)'(n_eff));
    sum_acc  = sum_r[s1_chan_r] + SUM_W'(s1_sample_r);
    sq_acc   = sq_r[s1_chan_r] + SQ_W'(s1_sq_r);
    pos_nxt  = pos + POS_W'(1);
    sum_nxt  = sum_r[s1_chan_r];
    sq_nxt   = sq_r[s1_chan_r];
    if (take) begin
      sum_nxt = sum_acc;
      sq_nxt  = sq_acc;
    end
    if (complete) begin
      pos_nxt = '0;
      sum_nxt = '0;
      sq_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        pos_r[i] <= '0;
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else if (s1_valid_r) begin
      pos_r[s1_chan_r] <= pos_nxt;
      sum_r[s1_chan_r] <= sum_nxt;
      sq_r[s1_chan_r]  <= sq_nxt;
    end
  end

  // Completed frame goes to the queue
  assign push = s1_valid_r & complete;

  always_comb begin
    job.chan = s1_chan_r[0];
    job.n    = n_eff;
    job.sum  = sum_acc;
    job.sq   = sq_acc;
  end

endmodule

[hdl/fdar_queue.sv]
`timescale 1ns / 1ps
// Short frame queue between the front and back ends.
module fdar_queue #(
  parameter int DEPTH = fdar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fdar_pkg::job_t   push_data,
  input  logic             pop,
  output fdar_pkg::job_t   head,
  output fdar_pkg::qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fdar_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head             = slot_r[rd_ptr_r];
  assign stat.empty       = (count_r == '0);
  assign stat.full        = (count_r == CNT_W'(DEPTH));
  assign stat.almost_full = (count_r >= CNT_W'(DEPTH - 1));

  // A frame is never pushed into a full queue or taken from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("frame queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("frame queue underflow");

endmodule

[hdl/fdar_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fdar_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fdar_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [fdar_pkg::DIVISOR_W-1:0]  divisor,
  output fdar_pkg::div_stat_t             stat,
  output logic [fdar_pkg::DIVIDEND_W-1:0] quotient
);

  localparam int DD_W  = fdar_pkg::DIVIDEND_W;
  localparam int DV_W  = fdar_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(DD_W + 1);

  logic [DD_W-1:0]  quo_r;
  logic [DV_W-1:0]  rem_r;
  logic [DV_W-1:0]  dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             ge;
  logic [DV_W-1:0]  rem_nxt;
  logic [DD_W-1:0]  quo_nxt;

  // One shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[DD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? DV_W'(diff) : DV_W'(trial);
    quo_nxt = {quo_r[DD_W-2:0], ge};
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DD_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[hdl/fdar_back.sv]
`timescale 1ns / 1ps
// Back end: per-frame mean, variance, square root and millivolt scaling.
module fdar_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fdar_pkg::qstat_t             qstat,
  input  fdar_pkg::job_t               head,
  input  logic [fdar_pkg::SCALE_W-1:0] mv_scale,
  output logic                         pop,
  output logic                         out_valid,
  output logic                         out_chan,
  output logic [fdar_pkg::N_W-1:0]     out_sample_count,
  output logic [fdar_pkg::OUT_W-1:0]   out_dc_code_q8,
  output logic [fdar_pkg::OUT_W-1:0]   out_rms_code_q8,
  output logic [fdar_pkg::OUT_W-1:0]   out_rms_mv_q4
);

  localparam int N_W     = fdar_pkg::N_W;
  localparam int SUM_W   = fdar_pkg::SUM_W;
  localparam int HALF_W  = fdar_pkg::SQ_HALF_W;
  localparam int PA_W    = fdar_pkg::PROD_A_W;
  localparam int PB_W    = fdar_pkg::PROD_B_W;
  localparam int DV_W    = fdar_pkg::DIVISOR_W;
  localparam int DD_W    = fdar_pkg::DIVIDEND_W;
  localparam int FRAC_W  = fdar_pkg::FRAC_W;
  localparam int ROOT_W  = fdar_pkg::ROOT_W;
  localparam int X_W     = fdar_pkg::X_W;
  localparam int OUT_W   = fdar_pkg::OUT_W;
  localparam int SCALE_W = fdar_pkg::SCALE_W;
  localparam int SHIFT   = fdar_pkg::MV_SHIFT;
  localparam int MV_W    = OUT_W + SCALE_W;
  localparam int PP_W    = N_W + HALF_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int SC_W    = $clog2(ROOT_W);
  localparam int DCN_W   = SUM_W + 8;

  fdar_pkg::bk_state_t state_r;
  fdar_pkg::bk_state_t state_nxt;

  fdar_pkg::job_t      job_r;
  logic [PA_W-1:0]     a_r;
  logic [PB_W-1:0]     b_r;
  logic [DV_W-1:0]     d_r;
  logic [PA_W-1:0]     var_r;
  logic [OUT_W-1:0]    dc_r;
  logic [X_W-1:0]      x_r;
  logic [ROOT_W-1:0]   root_r;
  logic [REM_W-1:0]    rem_r;
  logic [SC_W-1:0]     sq_cnt_r;
  logic [OUT_W-1:0]    r8_r;
  logic [OUT_W-1:0]    mv_r;

  logic [PP_W-1:0]     prod_lo;
  logic [PP_W-1:0]     prod_hi;
  logic [PB_W-1:0]     prod_b;
  logic [DV_W-1:0]     prod_d;
  logic [DCN_W-1:0]    dc_num;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    sq_trial;
  logic                sq_ge;
  logic [OUT_W-1:0]    r8_sat;
  logic [MV_W-1:0]     prod_mv;
  logic [MV_W-SHIFT-1:0] mv_raw;

  logic                div_start;
  logic [DD_W-1:0]     div_dividend;
  logic [DV_W-1:0]     div_divisor;
  fdar_pkg::div_stat_t div_stat;
  logic [DD_W-1:0]     div_quo;

  // Shared divider: mean first, then scaled variance
  fdar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdar_pkg::BK_IDLE: begin
        if (!qstat.empty) state_nxt = fdar_pkg::BK_MUL_LO;
      end
      fdar_pkg::BK_MUL_LO:  state_nxt = fdar_pkg::BK_MUL_HI;
      fdar_pkg::BK_MUL_HI:  state_nxt = fdar_pkg::BK_VAR;
      fdar_pkg::BK_VAR:     state_nxt = fdar_pkg::BK_DC_DIV;
      fdar_pkg::BK_DC_DIV: begin
        if (div_stat.done) state_nxt = fdar_pkg::BK_RMS_DIV;
      end
      fdar_pkg::BK_RMS_DIV: begin
        if (div_stat.done) state_nxt = fdar_pkg::BK_SQRT;
      end
      fdar_pkg::BK_SQRT: begin
        if (sq_cnt_r == SC_W'(ROOT_W - 1)) state_nxt = fdar_pkg::BK_SCALE;
      end
      fdar_pkg::BK_SCALE:   state_nxt = fdar_pkg::BK_EMIT;
      fdar_pkg::BK_EMIT:    state_nxt = fdar_pkg::BK_IDLE;
      default:              state_nxt = fdar_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdar_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control outputs and divider operands
  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    out_valid    = 1'b0;
    dc_num       = {job_r.sum, 8'd0} + DCN_W'(job_r.n >> 1);
    div_dividend = DD_W'(dc_num);
    div_divisor  = DV_W'(job_r.n);
    case (state_r)
      fdar_pkg::BK_IDLE:   pop = ~qstat.empty;
      fdar_pkg::BK_VAR:    div_start = 1'b1;
      fdar_pkg::BK_DC_DIV: begin
        div_start    = div_stat.done;
        div_dividend = {var_r, FRAC_W'(0)};
        div_divisor  = d_r;
      end
      fdar_pkg::BK_EMIT:   out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  // Products, split where the operand is wide
  always_comb begin
    prod_lo = job_r.n * job_r.sq[HALF_W-1:0];
    prod_hi = job_r.n * job_r.sq[2*HALF_W-1:HALF_W];
    prod_b  = job_r.sum * job_r.sum;
    prod_d  = job_r.n * job_r.n;
  end

  // Square root step: two radicand bits per cycle
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], x_r[X_W-1 -: 2]};
    sq_trial = REM_W'({root_r, 2'b01});
    sq_ge    = (rem_sh >= sq_trial);
  end

  // Saturate root, then scale to millivolts
  always_comb begin
    r8_sat  = (root_r > ROOT_W'(fdar_pkg::OUT_MAX)) ? fdar_pkg::OUT_MAX : OUT_W'(root_r);
    prod_mv = r8_sat * mv_scale;
    mv_raw  = prod_mv[MV_W-1:SHIFT];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      fdar_pkg::BK_IDLE: begin
        if (pop) job_r <= head;
      end
      fdar_pkg::BK_MUL_LO: begin
        a_r <= PA_W'(prod_lo);
        b_r <= prod_b;
        d_r <= prod_d;
      end
      fdar_pkg::BK_MUL_HI: begin
        a_r <= a_r + (PA_W'(prod_hi) << HALF_W);
      end
      fdar_pkg::BK_VAR: begin
        var_r <= (a_r > PA_W'(b_r)) ? a_r - PA_W'(b_r) : '0;
      end
      fdar_pkg::BK_DC_DIV: begin
        if (div_stat.done) begin
          dc_r <= (div_quo > DD_W'(fdar_pkg::OUT_MAX)) ? fdar_pkg::OUT_MAX : OUT_W'(div_quo);
        end
      end
      fdar_pkg::BK_RMS_DIV: begin
        if (div_stat.done) begin
          x_r      <= div_quo[X_W-1:0];
          root_r   <= '0;
          rem_r    <= '0;
          sq_cnt_r <= '0;
        end
      end
      fdar_pkg::BK_SQRT: begin
        x_r      <= {x_r[X_W-3:0], 2'b00};
        rem_r    <= sq_ge ? rem_sh - sq_trial : rem_sh;
        root_r   <= {root_r[ROOT_W-2:0], sq_ge};
        sq_cnt_r <= sq_cnt_r + SC_W'(1);
      end
      fdar_pkg::BK_SCALE: begin
        r8_r <= r8_sat;
        mv_r <= (mv_raw > (MV_W-SHIFT)'(fdar_pkg::OUT_MAX)) ? fdar_pkg::OUT_MAX
                                                            : OUT_W'(mv_raw);
      end
      default: begin
      end
    endcase
  end

  assign out_chan         = job_r.chan;
  assign out_sample_count = job_r.n;
  assign out_dc_code_q8   = dc_r;
  assign out_rms_code_q8  = r8_r;
  assign out_rms_mv_q4    = mv_r;

  // The divider is only restarted once the previous division has finished
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

endmodule

[verif/tb_frame_dc_and_ac_rms.sv]
`timescale 1ns / 1ps
// Testbench for frame_dc_and_ac_rms: directed and random sample streams, checked frame by frame.

// One completed frame as the block should report it
typedef struct packed {
  logic                         chan;
  logic [fdar_pkg::N_W-1:0]     count;
  logic [fdar_pkg::OUT_W-1:0]   dc;
  logic [fdar_pkg::OUT_W-1:0]   rms;
  logic [fdar_pkg::OUT_W-1:0]   mv;
} frame_result_t;

// Keeps per-channel frame state and the queue of frames still to be reported
class frame_rms_scoreboard;
  logic [fdar_pkg::DISC_W-1:0]  discard_cfg;
  logic [fdar_pkg::N_W-1:0]     valid_cfg;
  logic [fdar_pkg::SCALE_W-1:0] scale_cfg;
  int unsigned                  frame_pos [2];
  logic [fdar_pkg::SUM_W-1:0]   acc_sum [2];
  logic [fdar_pkg::SQ_W-1:0]    acc_sq [2];
  frame_result_t                expected_frames [$];
  int                           errors;
  int                           frames_seen;

  function new();
    discard_cfg = fdar_pkg::DISCARD_RST;
    valid_cfg   = fdar_pkg::VALID_RST;
    scale_cfg   = fdar_pkg::SCALE_RST;
    for (int c = 0; c < 2; c++) begin
      frame_pos[c] = 0;
      acc_sum[c]   = '0;
      acc_sq[c]    = '0;
    end
    errors      = 0;
    frames_seen = 0;
  endfunction

  function void write_reg(fdar_pkg::cfg_reg_t idx, logic [fdar_pkg::SCALE_W-1:0] data);
    case (idx)
      fdar_pkg::CFG_DISCARD: discard_cfg = data[fdar_pkg::DISC_W-1:0];
      fdar_pkg::CFG_VALID:   valid_cfg   = data[fdar_pkg::N_W-1:0];
      fdar_pkg::CFG_SCALE:   scale_cfg   = data;
      default: ;
    endcase
  endfunction

  // Frame length: zero means one, large values clamp to the maximum
  function int unsigned frame_len();
    int unsigned n;
    n = valid_cfg;
    if (n == 0) n = 1;
    if (n > fdar_pkg::MAX_VALID_DEF) n = fdar_pkg::MAX_VALID_DEF;
    return n;
  endfunction

  // Bitwise integer square root, floor
  function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function bit frame_open(logic ch);
    return frame_pos[ch] != 0;
  endfunction

  // Account one transferred sample; queue a result when it closes the frame
  function void note_sample(logic ch, logic [11:0] s);
    int unsigned   n;
    int unsigned   pos;
    logic [63:0]   n64, sum, sq, a, b, spread, d, q, r, x, r8, dc, mv;
    frame_result_t res;
    n   = frame_len();
    pos = frame_pos[ch];
    frame_pos[ch] = pos + 1;
    if (pos < discard_cfg) return;
    acc_sum[ch] = acc_sum[ch] + fdar_pkg::SUM_W'(s);
    acc_sq[ch]  = acc_sq[ch] + fdar_pkg::SQ_W'(s) * fdar_pkg::SQ_W'(s);
    if (pos + 1 - discard_cfg < n) return;

    sum = 64'(acc_sum[ch]);
    sq  = 64'(acc_sq[ch]);
    frame_pos[ch] = 0;
    acc_sum[ch]   = '0;
    acc_sq[ch]    = '0;

    n64 = 64'(n);
    dc  = (sum * 256 + n64 / 2) / n64;
    a   = n64 * sq;
    b   = sum * sum;
    spread = (a > b) ? a - b : 64'd0;
    d   = n64 * n64;
    q   = spread / d;
    r   = spread % d;
    x   = q * 65536 + (r * 65536) / d;
    r8  = int_sqrt(x);
    if (r8 > 64'(fdar_pkg::OUT_MAX)) r8 = 64'(fdar_pkg::OUT_MAX);
    mv  = (r8 * 64'(scale_cfg)) >> fdar_pkg::MV_SHIFT;

    res.chan  = ch;
    res.count = n[fdar_pkg::N_W-1:0];
    res.dc    = (dc > 64'(fdar_pkg::OUT_MAX)) ? fdar_pkg::OUT_MAX : dc[fdar_pkg::OUT_W-1:0];
    res.rms   = r8[fdar_pkg::OUT_W-1:0];
    res.mv    = (mv > 64'(fdar_pkg::OUT_MAX)) ? fdar_pkg::OUT_MAX : mv[fdar_pkg::OUT_W-1:0];
    expected_frames.push_back(res);
  endfunction

  function void compare_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      errors++;
    end
  endfunction

  // Compare one reported frame against the oldest queued one
  function void check_frame(frame_result_t got);
    frame_result_t want;
    frames_seen++;
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected result, expected none actual chan %0d dc %0d rms %0d",
               $time, got.chan, got.dc, got.rms);
      errors++;
      return;
    end
    want = expected_frames.pop_front();
    compare_field("out_chan", 32'(want.chan), 32'(got.chan));
    compare_field("out_sample_count", 32'(want.count), 32'(got.count));
    compare_field("out_dc_code_q8", 32'(want.dc), 32'(got.dc));
    compare_field("out_rms_code_q8", 32'(want.rms), 32'(got.rms));
    compare_field("out_rms_mv_q4", 32'(want.mv), 32'(got.mv));
  endfunction
endclass

module tb_frame_dc_and_ac_rms;

  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 330;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_chan;
  logic [11:0]                    in_sample;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [fdar_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fdar_pkg::SCALE_W-1:0]   cfg_data;
  logic                           out_valid;
  logic                           out_chan;
  logic [fdar_pkg::N_W-1:0]       out_sample_count;
  logic [fdar_pkg::OUT_W-1:0]     out_dc_code_q8;
  logic [fdar_pkg::OUT_W-1:0]     out_rms_code_q8;
  logic [fdar_pkg::OUT_W-1:0]     out_rms_mv_q4;

  frame_rms_scoreboard sb;
  int                  idle_cycles;
  int                  samples_sent;
  int                  settings_used;
  bit                  burst_mode;

  frame_dc_and_ac_rms dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_chan          (in_chan),
    .in_sample        (in_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_chan         (out_chan),
    .out_sample_count (out_sample_count),
    .out_dc_code_q8   (out_dc_code_q8),
    .out_rms_code_q8  (out_rms_code_q8),
    .out_rms_mv_q4    (out_rms_mv_q4)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        sb.check_frame('{out_chan, out_sample_count, out_dc_code_q8,
                         out_rms_code_q8, out_rms_mv_q4});
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d frames outstanding", $time,
                 sb.expected_frames.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sample values biased toward the rails and toward flat frames
  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'(2040 + $urandom_range(0, 15));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // One sample transfer; start stays high when the next one follows at once
  task automatic send_sample(input logic ch, input logic [11:0] s);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_chan   <= ch;
    in_sample <= s;
    do @(posedge clk); while (busy);
    sb.note_sample(ch, s);
    samples_sent++;
  endtask

  // Hold off input until every queued frame has been reported, then settle
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input fdar_pkg::cfg_reg_t idx,
                           input logic [fdar_pkg::SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Finish open frames on both channels, go idle, then load all three registers
  task automatic set_config(input int disc, input int valid, input int scale);
    for (int c = 0; c < 2; c++) begin
      while (sb.frame_open(c[0])) send_sample(c[0], pick_sample());
    end
    drain();
    write_cfg(fdar_pkg::CFG_DISCARD, fdar_pkg::SCALE_W'(disc));
    write_cfg(fdar_pkg::CFG_VALID, fdar_pkg::SCALE_W'(valid));
    write_cfg(fdar_pkg::CFG_SCALE, fdar_pkg::SCALE_W'(scale));
    settings_used++;
  endtask

  initial begin
    int disc;
    int valid;
    int scale;
    sb            = new();
    samples_sent  = 0;
    settings_used = 0;
    burst_mode    = 1'b0;
    idle_cycles   = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_chan       = 1'b0;
    in_sample     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = fdar_pkg::CFG_DISCARD;
    cfg_data      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample frames at the rails, full-scale gain
    set_config(0, 1, 24'hFFFFFF);
    send_sample(1'b0, 12'd0);
    send_sample(1'b1, 12'd4095);
    send_sample(1'b0, 12'd4095);
    send_sample(1'b1, 12'd0);

    // Two-sample frames: peak swing and a flat frame
    set_config(0, 2, fdar_pkg::SCALE_RST);
    send_sample(1'b0, 12'd0);
    send_sample(1'b0, 12'd4095);
    send_sample(1'b1, 12'd4095);
    send_sample(1'b1, 12'd4095);

    // Peak swing with maximum gain: millivolt output saturates
    set_config(0, 2, 24'hFFFFFF);
    send_sample(1'b0, 12'd4095);
    send_sample(1'b0, 12'd0);

    // Zero valid count behaves as one sample, zero gain
    set_config(0, 0, 0);
    send_sample(1'b1, 12'hA5A);
    send_sample(1'b0, 12'h5A5);

    // Leading discard with channels interleaved
    set_config(3, 2, 65536);
    for (int i = 0; i < 5; i++) begin
      send_sample(1'b0, 12'(1 + i * 50));
      send_sample(1'b1, 12'(4000 - i * 37));
    end

    // Random settings and streams, mostly short frames
    while (samples_sent < 22 + RANDOM_ITEMS) begin
      disc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
      valid = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
      case ($urandom_range(0, 3))
        0: scale = 0;
        1: scale = 24'hFFFFFF;
        2: scale = fdar_pkg::SCALE_RST;
        default: scale = $urandom_range(0, 24'hFFFFFF);
      endcase
      set_config(disc, valid, scale);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (40) send_sample(1'($urandom_range(0, 1)), pick_sample());
      burst_mode = 1'b0;
    end

    drain();

    $display("Run covered %0d samples under %0d register settings, %0d frames reported",
             samples_sent, settings_used, sb.frames_seen);
    if (sb.expected_frames.size() != 0) begin
      $display("%0t: %0d expected frames never reported", $time, sb.expected_frames.size());
    end
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[frame_dc_and_ac_rms.f]
hdl/fdar_pkg.sv
hdl/fdar_front.sv
hdl/fdar_queue.sv
hdl/fdar_div.sv
hdl/fdar_back.sv
hdl/frame_dc_and_ac_rms.sv
verif/tb_frame_dc_and_ac_rms.sv
